>>> rtl/core/assert_macros.svh
// assertion helpers for the tone map core
// both forms sample on clk_i; the first one is muted while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define HTM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define HTM_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define HTM_ASSERT(lbl, prop, msg)
`define HTM_ASSERT_RST(lbl, prop, msg)
`endif
`endif

>>> rtl/core/htm_pkg.sv
package htm_pkg;

  // field widths
  localparam int CH_W    = 24;
  localparam int GAIN_SH = 16;
  localparam int FRAC    = 16;
  localparam int OUT_W   = 16;
  localparam int X_W     = CH_W - 1;
  localparam int XX_W    = 2 * X_W;
  localparam int P_W     = X_W + CH_W;
  localparam int T_W     = 32;
  localparam int RW      = 57;
  localparam int DEN_LIM = 38;
  localparam int FILM_LIM = 40;
  localparam int REM_W   = DEN_LIM + 1;

  // chain lengths and total latency
  localparam int EXT_CELLS = T_W;
  localparam int RAT_CELLS = OUT_W;
  localparam int LAT       = 2 + EXT_CELLS + 1 + 5 + RAT_CELLS;

  localparam logic [X_W-1:0]   X_MAX      = '1;
  localparam logic [OUT_W-1:0] OUT_MAX    = '1;
  localparam logic [16:0]      FILM_NUM_K = 17'd91785;
  localparam logic [16:0]      FILM_DEN_K = 17'd66556;

  typedef enum logic [2:0] {
    CURVE_LINEAR   = 3'd0,
    CURVE_REINHARD = 3'd1,
    CURVE_EXT      = 3'd2,
    CURVE_ACES     = 3'd3,
    CURVE_FILMIC   = 3'd4
  } htm_curve_e;

  typedef enum logic [1:0] {
    REG_CURVE = 2'd0,
    REG_GAIN  = 2'd1,
    REG_WHITE = 2'd2
  } htm_reg_e;

  typedef struct packed {
    logic [2:0]      curve;
    logic [CH_W-1:0] gain;
    logic [CH_W-1:0] white;
  } htm_cfg_t;

  typedef struct packed {
    logic ld0;
    logic en;
  } htm_ctrl_t;

  // white point divide cell payload
  typedef struct packed {
    logic [CH_W-1:0] r;
    logic [T_W-1:0]  q;
    logic [X_W-1:0]  x;
  } htm_ext_t;

  // output ratio cell payload
  typedef struct packed {
    logic [REM_W-1:0] r;
    logic [OUT_W-1:0] lq;
    logic [REM_W-1:0] d;
    logic             sat;
  } htm_rat_t;

endpackage

>>> rtl/core/htm_div_cell.sv
module htm_div_cell
  import htm_pkg::*;
(
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [CH_W-1:0] w_i,
  input  htm_ext_t        d_i,
  output htm_ext_t        q_o
);

  logic [CH_W:0] r2;
  logic          ge;
  logic [CH_W:0] rn;
  htm_ext_t      st_d, st_q;

  // one quotient bit of x / white
  always_comb begin
    r2 = {d_i.r, 1'b0};
    ge = (r2 >= {1'b0, w_i});
    rn = ge ? (r2 - {1'b0, w_i}) : r2;
    st_d.r = rn[CH_W-1:0];
    st_d.q = {d_i.q[T_W-2:0], ge};
    st_d.x = d_i.x;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
    end
  end

  assign q_o = st_q;

endmodule

>>> rtl/core/htm_ratio_cell.sv
module htm_ratio_cell
  import htm_pkg::*;
(
  input  logic     clk_i,
  input  logic     en_i,
  input  htm_rat_t d_i,
  output htm_rat_t q_o
);

  logic [REM_W:0] r2;
  logic           ge;
  logic [REM_W:0] rn;
  htm_rat_t       st_d, st_q;

  // shift in next dividend bit, quotient bit shifts in at the bottom
  always_comb begin
    r2 = {d_i.r, d_i.lq[OUT_W-1]};
    ge = (r2 >= {1'b0, d_i.d});
    rn = ge ? (r2 - {1'b0, d_i.d}) : r2;
    st_d.r   = rn[REM_W-1:0];
    st_d.lq  = {d_i.lq[OUT_W-2:0], ge};
    st_d.d   = d_i.d;
    st_d.sat = d_i.sat;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
    end
  end

  assign q_o = st_q;

endmodule

>>> rtl/core/htm_channel.sv
module htm_channel
  import htm_pkg::*;
(
  input  logic             clk_i,
  input  htm_ctrl_t        ctrl_i,
  input  htm_cfg_t         cfg_i,
  input  logic [CH_W-1:0]  raw_i,
  output logic [OUT_W-1:0] out_o
);

  typedef struct packed {
    logic [RW-1:0] n;
    logic [RW-1:0] d;
  } pair_t;

  // greedy right shift of both terms until den is below 2^lim
  function automatic pair_t shrink(pair_t p, int unsigned lim);
    pair_t r;
    r = p;
    for (int j = 4; j >= 0; j--) begin
      if ((r.d >> (lim + (1 << j) - 1)) != '0) begin
        r.n = r.n >> (1 << j);
        r.d = r.d >> (1 << j);
      end
    end
    return r;
  endfunction

  // exposure product
  logic [P_W-1:0] p_d, p_q;
  assign p_d = raw_i[CH_W-1] ? '0 : (P_W'(raw_i[X_W-1:0]) * P_W'(cfg_i.gain));

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld0) begin
      p_q <= p_d;
    end
  end

  // saturate to the channel maximum
  logic [X_W-1:0] x_d, x_q;
  assign x_d = (|p_q[P_W-1:GAIN_SH+X_W]) ? X_MAX : p_q[GAIN_SH +: X_W];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      x_q <= x_d;
    end
  end

  // white point divide chain, t = x * 2^32 / w
  htm_ext_t ext [0:EXT_CELLS];
  assign ext[0].r = {1'b0, x_q};
  assign ext[0].q = '0;
  assign ext[0].x = x_q;

  for (genvar i = 0; i < EXT_CELLS; i++) begin : g_ext
    htm_div_cell u_cell (
      .clk_i (clk_i),
      .en_i  (ctrl_i.en),
      .w_i   (cfg_i.white),
      .d_i   (ext[i]),
      .q_o   (ext[i+1])
    );
  end

  // squares
  logic [2*T_W-1:0] tt;
  logic [T_W-1:0]   t2_q;
  logic [XX_W-1:0]  xx_q;
  logic [X_W-1:0]   xm_q;
  assign tt = ext[EXT_CELLS].q * ext[EXT_CELLS].q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      t2_q <= tt[2*T_W-1:T_W];
      xx_q <= ext[EXT_CELLS].x * ext[EXT_CELLS].x;
      xm_q <= ext[EXT_CELLS].x;
    end
  end

  // curve numerator and denominator
  logic [RW-1:0] xe, xxe, t2e, one;
  pair_t         p1_d, p1_q;

  always_comb begin
    xe  = RW'(xm_q);
    xxe = RW'(xx_q);
    t2e = RW'(t2_q);
    one = RW'(1) << FRAC;
    unique case (cfg_i.curve)
      CURVE_LINEAR: begin
        p1_d.n = xe;
        p1_d.d = one;
      end
      CURVE_REINHARD: begin
        p1_d.n = xe;
        p1_d.d = one + xe;
      end
      CURVE_EXT: begin
        if (cfg_i.white == '0) begin
          p1_d.n = xe;
          p1_d.d = one + xe;
        end else if ({1'b0, xm_q} >= cfg_i.white) begin
          p1_d.n = RW'(1);
          p1_d.d = RW'(1);
        end else begin
          p1_d.n = (xe << T_W) + (t2e << FRAC);
          p1_d.d = (one + xe) << T_W;
        end
      end
      CURVE_FILMIC: begin
        p1_d.n = xxe * RW'(42) + ((xe * RW'(5)) << FRAC);
        p1_d.d = xxe * RW'(45) + ((xe * RW'(150)) << FRAC) + (RW'(18) << (2 * FRAC));
      end
      default: begin
        p1_d.n = xxe * RW'(251) + ((xe * RW'(3)) << FRAC);
        p1_d.d = xxe * RW'(243) + ((xe * RW'(59)) << FRAC) + (RW'(14) << (2 * FRAC));
      end
    endcase
  end

  // filmic pre-scaling and constants, then normalization of every curve and the saturation flag
  pair_t p2_q, p3_q, p4_q, p3_d;
  logic  sat4_q;

  always_comb begin
    if (cfg_i.curve == CURVE_FILMIC) begin
      p3_d.n = p2_q.n * RW'(FILM_NUM_K);
      p3_d.d = p2_q.d * RW'(FILM_DEN_K);
    end else begin
      p3_d = p2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      p1_q   <= p1_d;
      p2_q   <= (cfg_i.curve == CURVE_FILMIC) ? shrink(p1_q, FILM_LIM) : p1_q;
      p3_q   <= p3_d;
      p4_q   <= shrink(p3_q, DEN_LIM);
      sat4_q <= (p3_q.n >= p3_q.d);
    end
  end

  // rounded dividend and doubled divisor
  logic [RW-1:0] nn;
  htm_rat_t      rat [0:RAT_CELLS];
  htm_rat_t      r0_d, r0_q;
  assign nn = p4_q.n * RW'(2 * OUT_MAX) + p4_q.d;

  always_comb begin
    r0_d.r   = nn[OUT_W +: REM_W];
    r0_d.lq  = nn[OUT_W-1:0];
    r0_d.d   = {p4_q.d[DEN_LIM-1:0], 1'b0};
    r0_d.sat = sat4_q;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      r0_q <= r0_d;
    end
  end

  assign rat[0] = r0_q;

  // output ratio chain
  for (genvar i = 0; i < RAT_CELLS; i++) begin : g_rat
    htm_ratio_cell u_cell (
      .clk_i (clk_i),
      .en_i  (ctrl_i.en),
      .d_i   (rat[i]),
      .q_o   (rat[i+1])
    );
  end

  assign out_o = rat[RAT_CELLS].sat ? OUT_MAX : rat[RAT_CELLS].lq;

endmodule

>>> rtl/core/hdr_tonemap_curve_core.sv
// hdr tone map core: one pixel word in, one tonemapped pixel word out.
// input channel: in_valid_i/in_ready_o with three signed Q8.16 channels.
// output channel: out_valid_o/out_ready_i with three 16-bit codes, value
// times 65535, saturated.
// config channel: cfg_valid_i/cfg_ready_o, always ready; index 0 curve,
// 1 exposure gain, 2 white point; index 3 is dropped. Write only while idle.
// throughput: one word per cycle while the output is not held. Each channel runs a 32-cell chain for the
// white point quotient and a 16-cell chain for the output ratio, one
// quotient bit per cell per cycle unless stalled, so the depth is 56 stages.
// stall: while the output word waits, the pipe freezes; the first stage
// still takes one word if it is empty.
// reset: pipe empties, registers return to aces, unity gain, white 4.0.
`include "assert_macros.svh"

module hdr_tonemap_curve_core
  import htm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [CH_W-1:0]  red_in_i,
  input  logic [CH_W-1:0]  green_in_i,
  input  logic [CH_W-1:0]  blue_in_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [OUT_W-1:0] red_out_o,
  output logic [OUT_W-1:0] green_out_o,
  output logic [OUT_W-1:0] blue_out_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_index_i,
  input  logic [CH_W-1:0]  cfg_data_i
);

  // configuration registers
  htm_cfg_t cfg_d, cfg_q;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (htm_reg_e'(cfg_index_i))
        REG_CURVE: cfg_d.curve = cfg_data_i[2:0];
        REG_GAIN:  cfg_d.gain  = cfg_data_i;
        REG_WHITE: cfg_d.white = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.curve <= CURVE_ACES;
      cfg_q.gain  <= CH_W'(1) << GAIN_SH;
      cfg_q.white <= CH_W'(4) << GAIN_SH;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // pipe control and valid chain
  htm_ctrl_t       ctrl;
  logic [LAT-1:0]  v_d, v_q;

  always_comb begin
    ctrl.en  = !v_q[LAT-1] || out_ready_i;
    ctrl.ld0 = ctrl.en || !v_q[0];
    v_d = v_q;
    if (ctrl.en) begin
      v_d[LAT-1:1] = v_q[LAT-2:0];
    end
    if (ctrl.ld0) begin
      v_d[0] = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_ready_o  = ctrl.ld0;
  assign out_valid_o = v_q[LAT-1];

  // per-channel pipes
  htm_channel u_red (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .cfg_i  (cfg_q),
    .raw_i  (red_in_i),
    .out_o  (red_out_o)
  );

  htm_channel u_green (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .cfg_i  (cfg_q),
    .raw_i  (green_in_i),
    .out_o  (green_out_o)
  );

  htm_channel u_blue (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .cfg_i  (cfg_q),
    .raw_i  (blue_in_i),
    .out_o  (blue_out_o)
  );

  // checks
  `HTM_ASSERT(a_stall_blocks, (out_valid_o && !out_ready_i && v_q[0]) |-> !in_ready_o, "accept during full stall")
  `HTM_ASSERT(a_accept_lands, (in_valid_i && in_ready_o) |=> v_q[0], "accepted word not in first stage")
  `HTM_ASSERT(a_stall_keeps, !ctrl.en |=> ($countones(v_q) >= $past($countones(v_q))), "word lost while stalled")
  `HTM_ASSERT_RST(a_rst_empty, !rst_ni |=> !out_valid_o, "output valid after reset")

endmodule

>>> test/testbench.sv
module testbench;
  import htm_pkg::*;

  // spare curve codes, both fall back to aces
  localparam logic [2:0] CURVE_SPARE5 = 3'd5;
  localparam logic [2:0] CURVE_SPARE7 = 3'd7;
  // register index past the last register, dropped by the core
  localparam logic [1:0] REG_NONE = 2'd3;
  localparam int IDLE_PCT  = 26;
  localparam int HOLD_LEN  = 300;
  localparam int STALL_MAX = 5000;
  localparam int RAND_PER_PHASE = 44;
  // extra words in the hold-off phase so the pipe fills and stalls
  localparam int HOLD_EXTRA = 40;
  localparam int NUM_PHASES = 11;

  typedef struct {
    logic [OUT_W-1:0] red;
    logic [OUT_W-1:0] green;
    logic [OUT_W-1:0] blue;
  } pixel_code_t;

  // expected pixel codes and the tone map predictor
  class tonemap_scoreboard;
    pixel_code_t      pending_px[$];
    int               errors;
    logic [2:0]       curve;
    logic [CH_W-1:0]  gain;
    logic [CH_W-1:0]  white;

    function new();
      errors = 0;
      curve  = CURVE_ACES;
      gain   = 24'h010000;
      white  = 24'h040000;
    endfunction

    function void write_reg(logic [1:0] idx, logic [CH_W-1:0] data);
      case (idx)
        REG_CURVE: curve = data[2:0];
        REG_GAIN:  gain  = data;
        REG_WHITE: white = data;
        default: ;
      endcase
    endfunction

    // curve value num/den scaled to a 16-bit code, rounded half up
    function longint unsigned scale_ratio(longint unsigned num, longint unsigned den);
      if (den == 0) return 0;
      if (num >= den) return 64'(OUT_MAX);
      while (den >= (64'd1 << DEN_LIM)) begin
        num = num >> 1;
        den = den >> 1;
      end
      if (den == 0) return 0;
      return (num * 64'(OUT_MAX) * 2 + den) / (2 * den);
    endfunction

    function longint unsigned expose(logic [CH_W-1:0] raw);
      longint unsigned p;
      if (raw[CH_W-1] || raw == 0 || gain == 0) return 0;
      p = (64'(raw) * 64'(gain)) >> GAIN_SH;
      return (p > 64'h7FFFFF) ? 64'h7FFFFF : p;
    endfunction

    function logic [OUT_W-1:0] map_channel(logic [CH_W-1:0] raw);
      longint unsigned x, s, n, d, w, t, t2;
      x = expose(raw);
      s = 64'd1 << FRAC;
      w = 64'(white);
      case (curve)
        CURVE_LINEAR:   return OUT_W'(scale_ratio(x, s));
        CURVE_REINHARD: return OUT_W'(scale_ratio(x, s + x));
        CURVE_EXT: begin
          if (w == 0) return OUT_W'(scale_ratio(x, s + x));
          if (x >= w) return OUT_MAX;
          t  = (x << 32) / w;
          t2 = (t * t) >> 32;
          return OUT_W'(scale_ratio((x << 32) + t2 * s, (s + x) << 32));
        end
        CURVE_FILMIC: begin
          n = 42 * x * x + 5 * x * s;
          d = 45 * x * x + 150 * x * s + 18 * s * s;
          while (d >= (64'd1 << FILM_LIM)) begin
            n = n >> 1;
            d = d >> 1;
          end
          return OUT_W'(scale_ratio(n * 64'(FILM_NUM_K), d * 64'(FILM_DEN_K)));
        end
        default: begin
          n = 251 * x * x + 3 * x * s;
          d = 243 * x * x + 59 * x * s + 14 * s * s;
          return OUT_W'(scale_ratio(n, d));
        end
      endcase
    endfunction

    function void note_pixel(logic [CH_W-1:0] r, logic [CH_W-1:0] g, logic [CH_W-1:0] b);
      pixel_code_t px;
      px.red   = map_channel(r);
      px.green = map_channel(g);
      px.blue  = map_channel(b);
      pending_px.push_back(px);
    endfunction

    function void check_pixel(logic [OUT_W-1:0] r, logic [OUT_W-1:0] g, logic [OUT_W-1:0] b);
      pixel_code_t px;
      if (pending_px.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected pixel word %h %h %h", r, g, b);
        return;
      end
      px = pending_px.pop_front();
      if (px.red !== r || px.green !== g || px.blue !== b) begin
        errors++;
        if (errors <= 10)
          $display("pixel mismatch: expected %h %h %h, got %h %h %h",
                   px.red, px.green, px.blue, r, g, b);
      end
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic [CH_W-1:0]  red_in_i = '0;
  logic [CH_W-1:0]  green_in_i = '0;
  logic [CH_W-1:0]  blue_in_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [OUT_W-1:0] red_out_o;
  logic [OUT_W-1:0] green_out_o;
  logic [OUT_W-1:0] blue_out_o;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [1:0]       cfg_index_i = '0;
  logic [CH_W-1:0]  cfg_data_i = '0;

  tonemap_scoreboard sb = new();
  bit calm;
  bit hold_req;
  int stall_cycles;

  hdr_tonemap_curve_core DUT (.*);

  // clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // config write, only while the pipe is empty
  task automatic write_cfg(logic [1:0] idx, logic [CH_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // offer one pixel word, at times with a random gap before it, never while calm
  task automatic send_pixel(logic [CH_W-1:0] r, logic [CH_W-1:0] g, logic [CH_W-1:0] b);
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    red_in_i   <= r;
    green_in_i <= g;
    blue_in_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_pixel(r, g, b);
  endtask

  function automatic logic [CH_W-1:0] rand_channel();
    case ($urandom_range(3))
      0: return CH_W'($urandom);
      1: return CH_W'($urandom_range(0, 32'h20000));
      2: return CH_W'($urandom_range(0, 32'h100000));
      default: return CH_W'($urandom_range(0, 32'h7FFFFF));
    endcase
  endfunction

  // wait for the pipe to drain before touching registers
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_px.size() != 0) @(posedge clk_i);
    repeat (LAT + 4) @(posedge clk_i);
  endtask

  // receiver: random ready (always ready while calm), long hold-off on request, checks each word
  initial begin
    int hold_cnt;
    hold_cnt = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) sb.check_pixel(red_out_o, green_out_o, blue_out_o);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = HOLD_LEN;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= calm ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // watchdog on cycles with no accepted word on any channel
  initial begin
    stall_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_MAX) begin
        $display("** hdr_tonemap_curve_core: FAILED **");
        $finish;
      end
    end
  end

  // main sequence
  initial begin
    logic [2:0]      curves [NUM_PHASES];
    logic [CH_W-1:0] gains  [NUM_PHASES];
    logic [CH_W-1:0] whites [NUM_PHASES];
    logic [CH_W-1:0] edge_vals [8];
    curves = '{CURVE_ACES, CURVE_LINEAR, CURVE_REINHARD, CURVE_EXT, CURVE_EXT, CURVE_EXT,
               CURVE_FILMIC, CURVE_SPARE7, CURVE_SPARE5, CURVE_FILMIC, CURVE_EXT};
    gains  = '{24'h010000, 24'h010000, 24'h020000, 24'h010000, 24'h010000, 24'hFFFFFF,
               24'h010000, 24'h000000, 24'h008000, 24'hFFFFFF, 24'h001000};
    whites = '{24'h040000, 24'h040000, 24'h040000, 24'h040000, 24'h000000, 24'hFFFFFF,
               24'h040000, 24'h040000, 24'h040000, 24'h040000, 24'h000001};
    edge_vals = '{24'h000000, 24'h7FFFFF, 24'h800000, 24'hFFFFFF,
                  24'h000001, 24'h010000, 24'h040000, 24'h0000FF};
    calm = 1'b0;
    hold_req = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) begin
        write_cfg(REG_CURVE, {21'd0, curves[ph]});
        write_cfg(REG_GAIN, gains[ph]);
        write_cfg(REG_WHITE, whites[ph]);
        if (ph == 4) write_cfg(REG_NONE, 24'hFFFFFF);
      end
      calm = (ph == 5);
      if (ph == 2) hold_req = 1'b1;
      // edge values of the channels, each phase for the curve at hand
      for (int i = 0; i < 8; i++)
        send_pixel(edge_vals[i], edge_vals[(i + 3) % 8], edge_vals[(i + 5) % 8]);
      if (ph == 3) begin
        // around the white point
        send_pixel(24'h03FFFF, 24'h040000, 24'h040001);
      end
      for (int i = 0; i < RAND_PER_PHASE + ((ph == 2) ? HOLD_EXTRA : 0); i++)
        send_pixel(rand_channel(), rand_channel(), rand_channel());
      drain();
    end

    if (sb.errors == 0 && sb.pending_px.size() == 0)
      $display("** hdr_tonemap_curve_core: PASSED **");
    else
      $display("** hdr_tonemap_curve_core: FAILED **");
    $finish;
  end

endmodule
